### rtl/lzw_byte_compressor_assert.svh
// Assertion macros shared by the LZW compressor RTL.
`ifndef LZW_BYTE_COMPRESSOR_ASSERT_SVH
`define LZW_BYTE_COMPRESSOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define LZW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzw assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define LZW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzw assertion failed");
`else
`define LZW_ASSERT_NOW(label, clk, rst, ante, cons)
`define LZW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/lzw_pkg.sv
// Types, constants and hash function of the LZW compressor.
package lzw_pkg;

   localparam int CODE_BITS     = 12;
   localparam int BYTE_BITS     = 8;
   localparam int OUT_CODE_BITS = 12;
   localparam int BASE_CODES    = 256;
   localparam int DICT_DEPTH    = 1 << CODE_BITS;

   typedef logic [CODE_BITS-1:0]     code_type;
   typedef logic [CODE_BITS:0]       count_type;
   typedef logic [BYTE_BITS-1:0]     byte_type;
   typedef logic [OUT_CODE_BITS-1:0] out_code_type;

   // One hash table slot: the pair (prefix, byte) and the code it stands for
   typedef struct packed {
      logic     valid;
      code_type prefix;
      byte_type data_byte;
      code_type code;
   } dict_entry_type;

   localparam int ENTRY_BITS = $bits(dict_entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_MISS,
      ST_FLUSH
   } lzw_state_type;

   // Home slot of a pair: byte in the top bits, xor the prefix code
   function automatic code_type hash_slot(code_type prefix, byte_type data_byte);
      code_type shifted;
      shifted = code_type'(data_byte) << (CODE_BITS - BYTE_BITS);
      return shifted ^ prefix;
   endfunction

endpackage

### rtl/lzw_byte_compressor.sv
// Top level of the streaming LZW byte compressor with a hashed dictionary.
//
//   channel  direction  payload                               handshake
//   req_     in         tdata[7:0] byte, tlast end of stream  tvalid/tready
//   rsp_     out        tdata[11:0] code, tlast final code    tvalid/tready
//
// A byte that only sets the prefix is taken in ST_IDLE alone. A dictionary hit
// passes ST_IDLE and ST_CHECK, with ST_CHECK repeated per extra linear probe; a miss adds ST_MISS.
// All probes share the single read port of the 4096-slot hash table RAM.
// After reset and after every end of stream a clearing pass in ST_CLEAR
// writes each slot empty; req_tready stays low meanwhile.
// Results leave through one output register; the sequencer stalls only when
// it has a code to emit and that register is still full.
`include "lzw_byte_compressor_assert.svh"

module lzw_byte_compressor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // in_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] out_code, [15:12] zero
   output logic        rsp_tlast    // out_last
);

   import lzw_pkg::*;

   lzw_state_type  state_ff, state_in;
   code_type       clr_ff, clr_in;
   count_type      next_free_ff, next_free_in;
   code_type       prefix_ff, prefix_in;
   logic           held_ff, held_in;
   byte_type       byte_ff, byte_in;
   logic           last_ff, last_in;
   code_type       probe_ff, probe_in;
   logic           rsp_valid_ff, rsp_valid_in;
   out_code_type   rsp_code_ff, rsp_code_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           accept;
   logic           out_free;
   logic           out_load;
   logic           dict_full;
   logic           wr_en;
   code_type       wr_addr;
   dict_entry_type wr_entry;
   code_type       rd_addr;
   dict_entry_type rd_entry;
   code_type       home_slot;
   logic           flush_fire;
   logic           hit_fire;

   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign dict_full = next_free_ff[CODE_BITS];
   assign home_slot = hash_slot(prefix_ff, req_tdata);

   // Hash table of (prefix, byte) pairs
   lzw_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DICT_DEPTH)
   ) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // Sequencer: next state, table access and output loads
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      next_free_in = next_free_ff;
      prefix_in    = prefix_ff;
      held_in      = held_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      probe_in     = probe_ff;
      req_tready   = 1'b0;
      rd_addr      = probe_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_entry     = '0;
      out_load     = 1'b0;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      flush_fire   = 1'b0;
      hit_fire     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + code_type'(1);
            if (clr_ff == code_type'(DICT_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               byte_in = req_tdata;
               last_in = req_tlast;
               if (!held_ff) begin
                  // first byte of a stream becomes the prefix
                  prefix_in = code_type'(req_tdata);
                  held_in   = 1'b1;
                  if (req_tlast) begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  rd_addr  = home_slot;
                  probe_in = home_slot;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (rd_entry.valid && rd_entry.prefix == prefix_ff &&
                rd_entry.data_byte == byte_ff) begin
               hit_fire  = 1'b1;
               prefix_in = rd_entry.code;
               state_in  = last_ff ? ST_FLUSH : ST_IDLE;
            end else if (rd_entry.valid) begin
               // advance to the next slot
               probe_in = probe_ff + code_type'(1);
               rd_addr  = probe_ff + code_type'(1);
            end else begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_code_in = out_code_type'(prefix_ff);
               rsp_last_in = 1'b0;
               if (!dict_full) begin
                  wr_en              = 1'b1;
                  wr_addr            = probe_ff;
                  wr_entry.valid     = 1'b1;
                  wr_entry.prefix    = prefix_ff;
                  wr_entry.data_byte = byte_ff;
                  wr_entry.code      = next_free_ff[CODE_BITS-1:0];
                  next_free_in       = next_free_ff + count_type'(1);
               end
               prefix_in = code_type'(byte_ff);
               state_in  = last_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               flush_fire   = 1'b1;
               out_load     = 1'b1;
               rsp_code_in  = out_code_type'(prefix_ff);
               rsp_last_in  = 1'b1;
               next_free_in = count_type'(BASE_CODES);
               prefix_in    = '0;
               held_in      = 1'b0;
               clr_in       = '0;
               state_in     = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // Hold the output item until taken, load a new one when free
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= count_type'(BASE_CODES);
         prefix_ff    <= '0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         prefix_ff    <= prefix_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      probe_ff    <= probe_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - OUT_CODE_BITS){1'b0}}, rsp_code_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Next free code never passes the table size
   `LZW_ASSERT_NOW(a_free_bound, clock, reset, dict_full, next_free_ff[CODE_BITS-1:0] == '0)
   // End of stream restores a fresh dictionary state
   `LZW_ASSERT_NEXT(a_flush_fresh, clock, reset, flush_fire, !held_ff && state_ff == ST_CLEAR && next_free_ff == count_type'(BASE_CODES))
   // A hit always lands on an assigned multi-byte code
   `LZW_ASSERT_NEXT(a_hit_code, clock, reset, hit_fire, prefix_ff >= code_type'(BASE_CODES) && count_type'(prefix_ff) < next_free_ff)
   // No item is taken while the clearing pass runs
   `LZW_ASSERT_NOW(a_clear_closed, clock, reset, state_ff == ST_CLEAR, !accept && !out_load)

endmodule

### rtl/lzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule
